// ===== src/dwmc_pkg.sv =====
`default_nettype none

package dwmc_pkg;

    // table size used when the top level is not told otherwise
    localparam int TABLE_ENTRIES_DEF = 1024;

    localparam int HASH_W  = 64;
    localparam int COUNT_W = 32;
    localparam int BYTE_W  = 8;
    localparam int REQ_W   = 3;

    // djb2 seed and word delimiters
    localparam logic [HASH_W-1:0] HASH_SEED  = 64'd5381;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;

    // request codes
    localparam logic [REQ_W-1:0] REQ_DICT  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TEXT  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_NEW   = 3'd4;

    // fan-in of the first level of the result tree
    localparam int REDUCE_GROUP = 32;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic              compare;
        logic              read_op;
        logic              text_inc;
        logic              insert;
        logic              clear;
        logic [HASH_W-1:0] key;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== src/dwmc_cell.sv =====
`default_nettype none

module dwmc_cell #(
    parameter int CELL_IDX = 0,
    parameter int SLOT_W   = 10,
    parameter int CNT_W    = 11
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire dwmc_pkg::cell_cmd_t             cmd,
    input  wire logic [CNT_W-1:0]                entry_count,
    input  wire logic [SLOT_W-1:0]               read_index,
    input  wire logic                            prev_lt,
    input  wire logic [dwmc_pkg::HASH_W-1:0]     prev_hash,
    input  wire logic [dwmc_pkg::COUNT_W-1:0]    prev_count,
    output logic                                 lt,
    output logic [dwmc_pkg::HASH_W-1:0]          hash,
    output logic [dwmc_pkg::COUNT_W-1:0]         count,
    // eq, hash, count, matched slot, insert slot
    output logic [dwmc_pkg::HASH_W+dwmc_pkg::COUNT_W+2*SLOT_W:0] leaf
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(CELL_IDX);
    localparam logic [CNT_W-1:0]  MY_POS  = CNT_W'(CELL_IDX);

    logic [dwmc_pkg::HASH_W-1:0]  hash_reg;
    logic [dwmc_pkg::COUNT_W-1:0] count_reg;
    logic                         lt_reg;
    logic                         eq_reg;
    logic                         rd_reg;
    logic                         in_use;
    logic                         at_or_below;
    logic                         edge_pos;
    logic                         shift_up;
    logic                         sel;

    assign in_use      = MY_POS < entry_count;
    assign at_or_below = MY_POS <= entry_count;
    // first cell not below the key: where a new word lands
    assign edge_pos    = prev_lt && !lt_reg && at_or_below;
    assign shift_up    = !prev_lt && at_or_below;
    assign sel         = eq_reg || rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.compare)
            begin
                lt_reg <= in_use && (hash_reg < cmd.key);
                eq_reg <= in_use && !cmd.read_op && (hash_reg == cmd.key);
                rd_reg <= in_use && cmd.read_op && (read_index == MY_SLOT);
            end
            priority if (cmd.clear)
                count_reg <= '0;
            else if (cmd.insert && edge_pos)
                count_reg <= '0;
            else if (cmd.insert && shift_up)
                count_reg <= prev_count;
            else if (cmd.text_inc && eq_reg)
                count_reg <= count_reg + dwmc_pkg::COUNT_W'(1);
            else
                count_reg <= count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert && edge_pos)
            hash_reg <= cmd.key;
        else if (cmd.insert && shift_up)
            hash_reg <= prev_hash;
    end

    assign lt    = lt_reg;
    assign hash  = hash_reg;
    assign count = count_reg;
    assign leaf  = {(edge_pos ? MY_SLOT : '0),
                    (eq_reg ? MY_SLOT : '0),
                    (sel ? count_reg : '0),
                    (sel ? hash_reg : '0),
                    eq_reg};

endmodule

`default_nettype wire

// ===== src/dwmc_reduce.sv =====
`default_nettype none

module dwmc_reduce #(
    parameter int N = 1024,
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic [W-1:0] leaf [N],
    output logic [W-1:0]      root
);

    localparam int GRP  = dwmc_pkg::REDUCE_GROUP;
    localparam int NGRP = (N + GRP - 1) / GRP;

    logic [W-1:0] grp_or  [NGRP];
    logic [W-1:0] grp_reg [NGRP];
    logic [W-1:0] root_or;
    logic [W-1:0] root_reg;

    // at most one leaf per field is nonzero, so an or-tree selects it
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_or[g] = '0;
            for (int k = 0; k < GRP; k++)
            begin
                if (g * GRP + k < N)
                    grp_or[g] = grp_or[g] | leaf[g * GRP + k];
            end
        end
    end

    always_comb
    begin
        root_or = '0;
        for (int g = 0; g < NGRP; g++)
            root_or = root_or | grp_reg[g];
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGRP; g++)
            grp_reg[g] <= grp_or[g];
        root_reg <= root_or;
    end

    assign root = root_reg;

endmodule

`default_nettype wire

// ===== src/dictionary_word_match_counter.sv =====
`default_nettype none

// Dictionary word match counter. Each item carries a request kind in s_tuser:
// dictionary byte, text byte, clear counts, read entry or start new dictionary.
// Space and newline end a word (an empty word is a word too); words are hashed
// with 64-bit djb2. The table lives in a chain of TABLE_ENTRIES cells kept in
// ascending hash order; each cell holds one hash and its 32-bit wrapping match
// count and passes both to its upper neighbor when a new dictionary word is
// inserted below it. Every item gives exactly one result item. An item is
// accepted, then every cell compares the key against its hash, then the
// registered or-tree collects the matching cell's slot, count and hash, and
// last the cells update and the result is loaded into the output register.
// The last step waits while the previous result has not been taken, so with
// a slow sink the result rate follows m_tready. Counts and the entry count
// clear at reset directly; the stored hashes hold no reset value and are
// only ever read below the entry count.
module dictionary_word_match_counter #(
    parameter int TABLE_ENTRIES = dwmc_pkg::TABLE_ENTRIES_DEF,
    localparam int SLOT_W = $clog2(TABLE_ENTRIES),
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1),
    localparam int IN_W   = ((dwmc_pkg::BYTE_W + SLOT_W + 7) / 8) * 8,
    localparam int OUT_W  = ((4 + SLOT_W + dwmc_pkg::COUNT_W + dwmc_pkg::HASH_W
                              + CNT_W + 7) / 8) * 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // data_byte, entry_index
    input  wire logic [IN_W-1:0]            s_tdata,
    // req_type
    input  wire logic [dwmc_pkg::REQ_W-1:0] s_tuser,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // word_done, hit, slot, count_value, entry_hash, entry_valid,
    // entries_in_use, dict_full
    output logic [OUT_W-1:0]                m_tdata
);

    localparam int HASH_W  = dwmc_pkg::HASH_W;
    localparam int COUNT_W = dwmc_pkg::COUNT_W;
    localparam int LEAF_W  = HASH_W + COUNT_W + 2 * SLOT_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_RED1,
        ST_RED2,
        ST_FIN
    } state_t;

    state_t                     state_reg;
    logic [dwmc_pkg::REQ_W-1:0] req_reg;
    logic                       delim_reg;
    logic [SLOT_W-1:0]          idx_reg;
    logic [HASH_W-1:0]          key_reg;
    logic [HASH_W-1:0]          dict_hash_reg;
    logic [HASH_W-1:0]          text_hash_reg;
    logic [CNT_W-1:0]           entry_count_reg;
    logic                       full_reg;

    // output register
    logic                       m_tvalid_reg;
    logic                       out_done_reg;
    logic                       out_hit_reg;
    logic [SLOT_W-1:0]          out_slot_reg;
    logic [COUNT_W-1:0]         out_count_reg;
    logic [HASH_W-1:0]          out_hash_reg;
    logic                       out_valid_reg;

    // input unpacking
    logic [dwmc_pkg::BYTE_W-1:0] in_byte;
    logic [SLOT_W-1:0]           in_index;
    logic                        in_delim;
    logic                        accept;

    // cell chain
    dwmc_pkg::cell_cmd_t cmd;
    logic                cell_lt    [TABLE_ENTRIES];
    logic [HASH_W-1:0]   cell_hash  [TABLE_ENTRIES];
    logic [COUNT_W-1:0]  cell_count [TABLE_ENTRIES];
    logic                prev_lt    [TABLE_ENTRIES];
    logic [HASH_W-1:0]   prev_hash  [TABLE_ENTRIES];
    logic [COUNT_W-1:0]  prev_count [TABLE_ENTRIES];
    logic [LEAF_W-1:0]   leaves     [TABLE_ENTRIES];
    logic [LEAF_W-1:0]   root;

    logic                root_eq;
    logic [HASH_W-1:0]   root_hash;
    logic [COUNT_W-1:0]  root_count;
    logic [SLOT_W-1:0]   root_slot;
    logic [SLOT_W-1:0]   root_edge;

    // final step results
    logic                fire;
    logic                fin_done;
    logic                fin_hit;
    logic [SLOT_W-1:0]   fin_slot;
    logic [COUNT_W-1:0]  fin_count;
    logic [HASH_W-1:0]   fin_hash;
    logic                fin_valid;
    logic                fin_insert;
    logic                fin_clear;
    logic                fin_text_inc;
    logic [CNT_W-1:0]    entry_count_next;
    logic                full_next;

    assign in_byte  = s_tdata[dwmc_pkg::BYTE_W-1:0];
    assign in_index = s_tdata[dwmc_pkg::BYTE_W +: SLOT_W];
    assign in_delim = (in_byte == dwmc_pkg::CH_SPACE) || (in_byte == dwmc_pkg::CH_NEWLINE);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // result tree fields
    assign root_eq    = root[0];
    assign root_hash  = root[1 +: HASH_W];
    assign root_count = root[1 + HASH_W +: COUNT_W];
    assign root_slot  = root[1 + HASH_W + COUNT_W +: SLOT_W];
    assign root_edge  = root[1 + HASH_W + COUNT_W + SLOT_W +: SLOT_W];

    assign fire = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        fin_done         = 1'b0;
        fin_hit          = 1'b0;
        fin_slot         = '0;
        fin_count        = '0;
        fin_hash         = '0;
        fin_valid        = 1'b0;
        fin_insert       = 1'b0;
        fin_clear        = 1'b0;
        fin_text_inc     = 1'b0;
        entry_count_next = entry_count_reg;
        full_next        = full_reg;
        unique case (req_reg)
            dwmc_pkg::REQ_DICT:
            begin
                if (delim_reg)
                begin
                    fin_done = 1'b1;
                    fin_hash = key_reg;
                    if (root_eq)
                    begin
                        // duplicate word: table unchanged
                        fin_hit   = 1'b1;
                        fin_slot  = root_slot;
                        fin_count = root_count;
                    end
                    else if (entry_count_reg < CNT_W'(TABLE_ENTRIES))
                    begin
                        fin_insert       = 1'b1;
                        fin_slot         = root_edge;
                        entry_count_next = entry_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                end
            end
            dwmc_pkg::REQ_TEXT:
            begin
                if (delim_reg)
                begin
                    fin_done = 1'b1;
                    fin_hash = key_reg;
                    if (root_eq)
                    begin
                        fin_text_inc = 1'b1;
                        fin_hit      = 1'b1;
                        fin_slot     = root_slot;
                        fin_count    = root_count + COUNT_W'(1);
                    end
                end
            end
            dwmc_pkg::REQ_CLEAR:
            begin
                fin_clear = 1'b1;
            end
            dwmc_pkg::REQ_READ:
            begin
                fin_slot = idx_reg;
                if (CNT_W'(idx_reg) < entry_count_reg)
                begin
                    fin_valid = 1'b1;
                    fin_count = root_count;
                    fin_hash  = root_hash;
                end
            end
            dwmc_pkg::REQ_NEW:
            begin
                fin_clear        = 1'b1;
                entry_count_next = '0;
                full_next        = 1'b0;
            end
            default:
            begin
                // unused request kinds leave everything as it is
            end
        endcase
    end

    always_comb
    begin
        cmd.compare  = (state_reg == ST_CMP);
        cmd.read_op  = (req_reg == dwmc_pkg::REQ_READ);
        cmd.text_inc = fire && fin_text_inc;
        cmd.insert   = fire && fin_insert;
        cmd.clear    = fire && fin_clear;
        cmd.key      = key_reg;
    end

    // each cell sees its lower neighbor; the bottom cell sees a key above it
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        if (i == 0)
        begin : g_bottom
            assign prev_lt[i]    = 1'b1;
            assign prev_hash[i]  = '0;
            assign prev_count[i] = '0;
        end
        else
        begin : g_upper
            assign prev_lt[i]    = cell_lt[i-1];
            assign prev_hash[i]  = cell_hash[i-1];
            assign prev_count[i] = cell_count[i-1];
        end

        dwmc_cell #(
            .CELL_IDX (i),
            .SLOT_W   (SLOT_W),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .entry_count (entry_count_reg),
            .read_index  (idx_reg),
            .prev_lt     (prev_lt[i]),
            .prev_hash   (prev_hash[i]),
            .prev_count  (prev_count[i]),
            .lt          (cell_lt[i]),
            .hash        (cell_hash[i]),
            .count       (cell_count[i]),
            .leaf        (leaves[i])
        );
    end

    dwmc_reduce #(
        .N (TABLE_ENTRIES),
        .W (LEAF_W)
    ) u_reduce (
        .clk  (clk),
        .leaf (leaves),
        .root (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            dict_hash_reg   <= dwmc_pkg::HASH_SEED;
            text_hash_reg   <= dwmc_pkg::HASH_SEED;
            entry_count_reg <= '0;
            full_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_CMP;
                        req_reg   <= s_tuser;
                        delim_reg <= in_delim;
                        idx_reg   <= in_index;
                        // word hashes advance as the byte comes in
                        if (s_tuser == dwmc_pkg::REQ_DICT)
                        begin
                            if (in_delim)
                            begin
                                key_reg       <= dict_hash_reg;
                                dict_hash_reg <= dwmc_pkg::HASH_SEED;
                            end
                            else
                            begin
                                dict_hash_reg <= (dict_hash_reg << 5) + dict_hash_reg
                                                 + HASH_W'(in_byte);
                            end
                        end
                        else if (s_tuser == dwmc_pkg::REQ_TEXT)
                        begin
                            if (in_delim)
                            begin
                                key_reg       <= text_hash_reg;
                                text_hash_reg <= dwmc_pkg::HASH_SEED;
                            end
                            else
                            begin
                                text_hash_reg <= (text_hash_reg << 5) + text_hash_reg
                                                 + HASH_W'(in_byte);
                            end
                        end
                        else if (s_tuser == dwmc_pkg::REQ_NEW)
                        begin
                            dict_hash_reg <= dwmc_pkg::HASH_SEED;
                        end
                    end
                end
                ST_CMP:
                begin
                    state_reg <= ST_RED1;
                end
                ST_RED1:
                begin
                    state_reg <= ST_RED2;
                end
                ST_RED2:
                begin
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (fire)
                    begin
                        state_reg       <= ST_IDLE;
                        entry_count_reg <= entry_count_next;
                        full_reg        <= full_next;
                        out_done_reg    <= fin_done;
                        out_hit_reg     <= fin_hit;
                        out_slot_reg    <= fin_slot;
                        out_count_reg   <= fin_count;
                        out_hash_reg    <= fin_hash;
                        out_valid_reg   <= fin_valid;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (fire)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    // entries_in_use and dict_full are sampled with the result
    assign m_tdata  = OUT_W'({full_reg, entry_count_reg, out_valid_reg, out_hash_reg,
                              out_count_reg, out_slot_reg, out_hit_reg, out_done_reg});

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count above table size");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> (entry_count_reg == CNT_W'(TABLE_ENTRIES)))
        else $error("full flag set while table has room");

    a_accept_starts_compare: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_CMP))
        else $error("accepted item did not reach compare step");

    a_hit_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && out_hit_reg) |-> out_done_reg)
        else $error("hit reported without a finished word");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/dictionary_word_match_counter_tb.sv =====
`default_nettype none

module dictionary_word_match_counter_tb;

    localparam int HASH_W  = dwmc_pkg::HASH_W;
    localparam int COUNT_W = dwmc_pkg::COUNT_W;
    localparam int BYTE_W  = dwmc_pkg::BYTE_W;
    localparam int REQ_W   = dwmc_pkg::REQ_W;

    // sizes as the block derives them from its default table size
    localparam int TABLE_SIZE = dwmc_pkg::TABLE_ENTRIES_DEF;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int USED_W     = $clog2(TABLE_SIZE + 1);
    localparam int S_DATA_W   = ((BYTE_W + IDX_W + 7) / 8) * 8;
    localparam int M_DATA_W   = ((4 + IDX_W + COUNT_W + HASH_W + USED_W + 7) / 8) * 8;

    // request codes the block ignores
    localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_C = 3'd7;

    localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;

    localparam int RANDOM_ITEMS = 1150;
    localparam int FILL_WORDS   = 100;   // distinct two-byte dictionary words
    localparam int LOW_SPAN     = 31;    // second byte values 0..31 without newline
    localparam int IDLE_PCT     = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 5000;

    // one input item as the sender sees it
    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [BYTE_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
    } request_t;

    // one result item, word_done in the lowest bit as on m_tdata
    typedef struct packed {
        logic                dict_full;
        logic [USED_W-1:0]   entries_in_use;
        logic                entry_valid;
        logic [HASH_W-1:0]   entry_hash;
        logic [COUNT_W-1:0]  count_value;
        logic [IDX_W-1:0]    slot;
        logic                hit;
        logic                word_done;
    } match_result_t;

    localparam int RESULT_W = $bits(match_result_t);

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    // data_byte, entry_index
    logic [S_DATA_W-1:0] s_tdata;
    // req_type
    logic [REQ_W-1:0]    s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    // word_done, hit, slot, count_value, entry_hash, entry_valid,
    // entries_in_use, dict_full
    logic [M_DATA_W-1:0] m_tdata;

    dictionary_word_match_counter u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // shadow of the block's dictionary table and running word hashes
    logic [HASH_W-1:0]  dict_hash;
    logic [HASH_W-1:0]  text_hash;
    logic [HASH_W-1:0]  table_hash [TABLE_SIZE];
    logic [COUNT_W-1:0] table_count [TABLE_SIZE];
    int                 table_used;
    logic               table_full;

    request_t       pending_requests [$];   // items not yet offered
    match_result_t  awaited_results [$];    // predicted results in order
    int             requests_queued;
    int             results_seen = 0;
    int             mismatch_count;
    int             stall_cycles = 0;
    int             hold_left;
    logic           hold_done;

    request_t       drive_req;
    request_t       taken_req;
    match_result_t  predicted;
    match_result_t  observed;
    match_result_t  wanted;

    // no random idling on either side inside this window of results
    wire steady_window = (results_seen >= 600) && (results_seen < 1000);

    //------------------------------------------------------------------
    // predictor
    //------------------------------------------------------------------

    // djb2 step: hash * 33 + byte, wrapping at 64 bits
    function automatic logic [HASH_W-1:0] next_hash(input logic [HASH_W-1:0] h,
                                                    input logic [BYTE_W-1:0] ch);
        return (h << 5) + h + HASH_W'(ch);
    endfunction

    // table position holding h, or -1
    function automatic int find_slot(input logic [HASH_W-1:0] h);
        int k;
        for (k = 0; k < table_used; k++)
        begin
            if (table_hash[k] == h)
                return k;
        end
        return -1;
    endfunction

    task automatic process_request(input request_t rq, output match_result_t res);
        logic              delim;
        logic [HASH_W-1:0] word;
        int                found;
        int                pos;
        int                k;
        res   = '0;
        delim = (rq.ch == dwmc_pkg::CH_SPACE) || (rq.ch == dwmc_pkg::CH_NEWLINE);
        case (rq.req)
            dwmc_pkg::REQ_DICT:
            begin
                if (!delim)
                    dict_hash = next_hash(dict_hash, rq.ch);
                else
                begin
                    word            = dict_hash;
                    dict_hash       = dwmc_pkg::HASH_SEED;
                    res.word_done   = 1'b1;
                    res.entry_hash  = word;
                    found           = find_slot(word);
                    if (found >= 0)
                    begin
                        // duplicate word, table unchanged
                        res.hit         = 1'b1;
                        res.slot        = found[IDX_W-1:0];
                        res.count_value = table_count[found];
                    end
                    else if (table_used < TABLE_SIZE)
                    begin
                        // sorted insert, higher entries move up with their counts
                        pos = 0;
                        while (pos < table_used && table_hash[pos] < word)
                            pos++;
                        for (k = table_used; k > pos; k--)
                        begin
                            table_hash[k]  = table_hash[k-1];
                            table_count[k] = table_count[k-1];
                        end
                        table_hash[pos]  = word;
                        table_count[pos] = '0;
                        table_used++;
                        res.slot = pos[IDX_W-1:0];
                    end
                    else
                        table_full = 1'b1;
                end
            end
            dwmc_pkg::REQ_TEXT:
            begin
                if (!delim)
                    text_hash = next_hash(text_hash, rq.ch);
                else
                begin
                    word           = text_hash;
                    text_hash      = dwmc_pkg::HASH_SEED;
                    res.word_done  = 1'b1;
                    res.entry_hash = word;
                    found          = find_slot(word);
                    if (found >= 0)
                    begin
                        table_count[found] = table_count[found] + COUNT_W'(1);
                        res.hit            = 1'b1;
                        res.slot           = found[IDX_W-1:0];
                        res.count_value    = table_count[found];
                    end
                end
            end
            dwmc_pkg::REQ_CLEAR:
            begin
                for (k = 0; k < TABLE_SIZE; k++)
                    table_count[k] = '0;
            end
            dwmc_pkg::REQ_READ:
            begin
                res.slot = rq.idx;
                if (int'(rq.idx) < table_used)
                begin
                    res.entry_valid = 1'b1;
                    res.count_value = table_count[rq.idx];
                    res.entry_hash  = table_hash[rq.idx];
                end
            end
            dwmc_pkg::REQ_NEW:
            begin
                // running text word survives a new dictionary
                table_used = 0;
                table_full = 1'b0;
                dict_hash  = dwmc_pkg::HASH_SEED;
                for (k = 0; k < TABLE_SIZE; k++)
                    table_count[k] = '0;
            end
            default:
            begin
                // spare codes leave everything alone
            end
        endcase
        res.entries_in_use = table_used[USED_W-1:0];
        res.dict_full      = table_full;
    endtask

    //------------------------------------------------------------------
    // stimulus helpers
    //------------------------------------------------------------------

    task automatic queue_request(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] ch,
                                 input logic [IDX_W-1:0] idx);
        request_t rq;
        rq.req = req;
        rq.ch  = ch;
        rq.idx = idx;
        pending_requests.push_back(rq);
        requests_queued++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_delim();
        return $urandom_range(0, 1) ? dwmc_pkg::CH_SPACE : dwmc_pkg::CH_NEWLINE;
    endfunction

    // short word over a four-letter alphabet so text often hits the table
    task automatic queue_word(input logic [REQ_W-1:0] stream, input int len);
        int k;
        for (k = 0; k < len; k++)
            queue_request(stream, CH_LOWER_A + BYTE_W'($urandom_range(0, 3)),
                          IDX_W'($urandom_range(0, 1023)));
        queue_request(stream, pick_delim(), IDX_W'($urandom_range(0, 1023)));
    endtask

    // j-th word of the fill set: two bytes, distinct for every j
    task automatic queue_fill_word(input logic [REQ_W-1:0] stream, input int base,
                                   input int j);
        int lo;
        lo = j % LOW_SPAN;
        if (lo >= int'(dwmc_pkg::CH_NEWLINE))
            lo++;
        queue_request(stream, BYTE_W'(base + j / LOW_SPAN), IDX_W'($urandom_range(0, 1023)));
        queue_request(stream, BYTE_W'(lo), IDX_W'($urandom_range(0, 1023)));
        queue_request(stream, pick_delim(), IDX_W'($urandom_range(0, 1023)));
    endtask

    // sender pause: nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || s_tvalid || awaited_results.size() != 0);
    endtask

    //------------------------------------------------------------------
    // clock
    //------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    //------------------------------------------------------------------
    // driver: offers queued items, idles at random
    //------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (pending_requests.size() != 0
                && (steady_window || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                drive_req = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= S_DATA_W'({drive_req.idx, drive_req.ch});
                s_tuser  <= drive_req.req;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    //------------------------------------------------------------------
    // receiver: random stalls plus one long hold-off
    //------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_seen >= 150)
        begin
            // sender keeps offering, so the block backs up into s_tready
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            m_tready <= steady_window || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    //------------------------------------------------------------------
    // monitor: predict on input accept, check on output accept
    //------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                observed = m_tdata[RESULT_W-1:0];
                results_seen <= results_seen + 1;
                if (awaited_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result item at %0t: %h", $time, m_tdata);
                end
                else
                begin
                    wanted = awaited_results.pop_front();
                    if (observed.word_done !== wanted.word_done
                        || observed.hit !== wanted.hit
                        || observed.slot !== wanted.slot
                        || observed.count_value !== wanted.count_value
                        || observed.entry_hash !== wanted.entry_hash
                        || observed.entry_valid !== wanted.entry_valid
                        || observed.entries_in_use !== wanted.entries_in_use
                        || observed.dict_full !== wanted.dict_full)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("mismatch at %0t, result %0d", $time, results_seen);
                            $display("  exp done=%0d hit=%0d slot=%0d cnt=%0d",
                                     wanted.word_done, wanted.hit, wanted.slot,
                                     wanted.count_value);
                            $display("      hash=%h valid=%0d used=%0d full=%0d",
                                     wanted.entry_hash, wanted.entry_valid,
                                     wanted.entries_in_use, wanted.dict_full);
                            $display("  got done=%0d hit=%0d slot=%0d cnt=%0d",
                                     observed.word_done, observed.hit, observed.slot,
                                     observed.count_value);
                            $display("      hash=%h valid=%0d used=%0d full=%0d",
                                     observed.entry_hash, observed.entry_valid,
                                     observed.entries_in_use, observed.dict_full);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                taken_req.req = s_tuser;
                taken_req.ch  = s_tdata[BYTE_W-1:0];
                taken_req.idx = s_tdata[BYTE_W +: IDX_W];
                process_request(taken_req, predicted);
                awaited_results.push_back(predicted);
            end
        end
    end

    //------------------------------------------------------------------
    // watchdog: too long without any accepted item on either side
    //------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    //------------------------------------------------------------------
    // test sequence
    //------------------------------------------------------------------

    initial
    begin : sequencer
        int pick;
        int k;
        int base;
        int len;

        rst_n           = 1'b0;
        dict_hash       = dwmc_pkg::HASH_SEED;
        text_hash       = dwmc_pkg::HASH_SEED;
        table_used      = 0;
        table_full      = 1'b0;
        requests_queued = 0;
        mismatch_count  = 0;
        for (k = 0; k < TABLE_SIZE; k++)
        begin
            table_hash[k]  = '0;
            table_count[k] = '0;
        end

        // directed: empty table read, spare codes, empty word, extreme bytes,
        // duplicate, hit, miss, interleaved streams, clear, new dictionary
        queue_request(dwmc_pkg::REQ_READ, 8'hff, '0);
        queue_request(REQ_SPARE_A, 8'h00, '0);
        queue_request(REQ_SPARE_B, 8'h55, 10'h2aa);
        queue_request(REQ_SPARE_C, 8'hff, '1);
        queue_request(dwmc_pkg::REQ_DICT, dwmc_pkg::CH_SPACE, '0);
        queue_request(dwmc_pkg::REQ_DICT, 8'h00, '0);
        queue_request(dwmc_pkg::REQ_DICT, 8'hff, '0);
        queue_request(dwmc_pkg::REQ_DICT, dwmc_pkg::CH_NEWLINE, '0);
        queue_request(dwmc_pkg::REQ_DICT, CH_LOWER_A, '0);
        queue_request(dwmc_pkg::REQ_DICT, dwmc_pkg::CH_SPACE, '0);
        queue_request(dwmc_pkg::REQ_DICT, CH_LOWER_A, '0);
        queue_request(dwmc_pkg::REQ_DICT, dwmc_pkg::CH_NEWLINE, '0);
        queue_request(dwmc_pkg::REQ_TEXT, CH_LOWER_A, '0);
        queue_request(dwmc_pkg::REQ_TEXT, dwmc_pkg::CH_SPACE, '0);
        queue_request(dwmc_pkg::REQ_TEXT, dwmc_pkg::CH_NEWLINE, '0);
        queue_request(dwmc_pkg::REQ_TEXT, CH_LOWER_A, '0);
        queue_request(dwmc_pkg::REQ_DICT, CH_LOWER_A + 8'd1, '0);
        queue_request(dwmc_pkg::REQ_TEXT, dwmc_pkg::CH_SPACE, '0);
        queue_request(dwmc_pkg::REQ_DICT, dwmc_pkg::CH_SPACE, '0);
        queue_request(dwmc_pkg::REQ_READ, 8'h00, 10'd2);
        queue_request(dwmc_pkg::REQ_READ, 8'h00, '1);
        queue_request(dwmc_pkg::REQ_CLEAR, 8'h00, '0);
        queue_request(dwmc_pkg::REQ_READ, 8'h00, 10'd2);
        queue_request(dwmc_pkg::REQ_TEXT, CH_LOWER_A + 8'd2, '0);
        queue_request(dwmc_pkg::REQ_NEW, 8'h00, '0);
        queue_request(dwmc_pkg::REQ_TEXT, dwmc_pkg::CH_SPACE, '0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait_drained();

        // random mix, mostly well-formed words over a small alphabet
        base = requests_queued;
        while (requests_queued - base < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
                queue_word(dwmc_pkg::REQ_TEXT, $urandom_range(0, 3));
            else if (pick < 60)
                queue_word(dwmc_pkg::REQ_DICT, $urandom_range(0, 3));
            else if (pick < 72)
                queue_request($urandom_range(0, 1) ? dwmc_pkg::REQ_DICT : dwmc_pkg::REQ_TEXT,
                              BYTE_W'($urandom_range(0, 255)),
                              IDX_W'($urandom_range(0, 1023)));
            else if (pick < 84)
                queue_request(dwmc_pkg::REQ_READ, BYTE_W'($urandom_range(0, 255)),
                              IDX_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                                 : $urandom_range(0, 95)));
            else if (pick < 89)
                queue_request(dwmc_pkg::REQ_CLEAR, BYTE_W'($urandom_range(0, 255)),
                              IDX_W'($urandom_range(0, 1023)));
            else if (pick < 91)
                queue_request(dwmc_pkg::REQ_NEW, BYTE_W'($urandom_range(0, 255)),
                              IDX_W'($urandom_range(0, 1023)));
            else if (pick < 96)
                queue_request(REQ_W'($urandom_range(REQ_SPARE_A, REQ_SPARE_C)),
                              BYTE_W'($urandom_range(0, 255)),
                              IDX_W'($urandom_range(0, 1023)));
            else
            begin
                // word broken up by other requests in the middle
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++)
                    queue_request(dwmc_pkg::REQ_TEXT,
                                  CH_LOWER_A + BYTE_W'($urandom_range(0, 3)), '0);
                queue_request($urandom_range(0, 1) ? dwmc_pkg::REQ_READ : dwmc_pkg::REQ_CLEAR,
                              BYTE_W'($urandom_range(0, 255)),
                              IDX_W'($urandom_range(0, 15)));
                queue_request(dwmc_pkg::REQ_TEXT, pick_delim(), '0);
            end
        end
        wait_drained();

        // larger dictionary of distinct two-byte words mixed with text lookups
        base = $urandom_range(33, 200);
        queue_request(dwmc_pkg::REQ_NEW, 8'h00, '0);
        queue_request(dwmc_pkg::REQ_DICT, dwmc_pkg::CH_SPACE, '0);
        for (k = 0; k < FILL_WORDS; k++)
        begin
            queue_fill_word(dwmc_pkg::REQ_DICT, base, k);
            if (k % 40 == 39)
                queue_fill_word(dwmc_pkg::REQ_TEXT, base, $urandom_range(0, k));
        end
        // hits and misses, duplicates, reads across and beyond the table
        for (k = 0; k < 30; k++)
            queue_fill_word(dwmc_pkg::REQ_TEXT, base, $urandom_range(0, 2 * FILL_WORDS - 1));
        for (k = 0; k < 10; k++)
            queue_fill_word(dwmc_pkg::REQ_DICT, base, $urandom_range(0, FILL_WORDS - 1));
        for (k = 0; k < 40; k++)
            queue_request(dwmc_pkg::REQ_READ, BYTE_W'($urandom_range(0, 255)),
                          IDX_W'($urandom_range(0, 127)));
        queue_request(dwmc_pkg::REQ_READ, 8'h00, '1);
        queue_request(dwmc_pkg::REQ_READ, 8'h00, '0);
        queue_request(dwmc_pkg::REQ_CLEAR, 8'h00, '0);
        for (k = 0; k < 10; k++)
            queue_fill_word(dwmc_pkg::REQ_TEXT, base, $urandom_range(0, FILL_WORDS - 1));
        queue_request(dwmc_pkg::REQ_READ, 8'h00, '1);
        queue_request(dwmc_pkg::REQ_NEW, 8'h00, '0);
        for (k = 0; k < 10; k++)
            queue_word(dwmc_pkg::REQ_DICT, $urandom_range(0, 3));
        for (k = 0; k < 10; k++)
            queue_word(dwmc_pkg::REQ_TEXT, $urandom_range(0, 3));
        wait_drained();

        // let any late extra result show up
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
